FILE: src/apfc_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the animation phase frame cache.
package apfc_pkg;

    // Sizing
    localparam int NUM_SLOTS  = 4;
    localparam int MAX_PASSES = 8;
    localparam int FRAC_BITS  = 8;

    localparam int SLOT_W      = $clog2(NUM_SLOTS);
    localparam int PASS_W      = $clog2(MAX_PASSES + 1);
    localparam int FRAME_W     = 7;
    localparam int PHASE_W     = FRAME_W + FRAC_BITS;
    localparam int SPEED_W     = 8;
    localparam int RATE_W      = 4;
    localparam int ADDR_W      = 32;
    localparam int SIZE_W      = 24;
    localparam int OUT_SLOT_W  = 2;
    localparam int OUT_PHASE_W = 15;

    // (speed << FRAC_BITS) / 60 as speed * RECIP >> DIV_K; the error stays below 1/60
    localparam int TICK_RATE = 60;
    localparam int DIV_K     = 14;
    localparam int RECIP_W   = FRAC_BITS + 9;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'((1 << (FRAC_BITS + DIV_K)) / TICK_RATE + 1);
    localparam int DBASE_W   = FRAC_BITS + 3;
    localparam int DELTA_W   = DBASE_W + RATE_W;
    localparam int PROD_W    = SPEED_W + RECIP_W;

    // signed working phase: room for the swing of repeated reflections
    localparam int ACC_W = FRAC_BITS + 12 + $clog2(MAX_PASSES);

    // APB
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    typedef enum logic [2:0] {
        REG_ENABLE,
        REG_FRAME_COUNT,
        REG_SPEED,
        REG_LOOP,
        REG_PINGPONG,
        REG_DATA_BASE,
        REG_FRAME_SIZE
    } t_reg_idx;

    typedef struct packed {
        logic                enable;
        logic [FRAME_W-1:0]  frame_count;
        logic [SPEED_W-1:0]  speed;
        logic                loop_en;
        logic                pp_en;
        logic [ADDR_W-1:0]   data_base;
        logic [SIZE_W-1:0]   frame_size;
    } t_cfg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BASE,
        S_SCALE,
        S_PASS,
        S_FINISH,
        S_LOOKUP,
        S_LOAD_CUR,
        S_LOAD_NXT,
        S_STATUS,
        S_DIS
    } t_state;

    typedef struct packed {
        logic accept;
        logic calc_base;
        logic scale;
        logic step;
        logic finish;
        logic lookup;
        logic load_cur;
        logic load_nxt;
        logic emit_status;
        logic emit_dis;
    } t_dp_cmd;

    typedef struct packed {
        logic skip;
        logic pass_last;
        logic cur_load;
        logic nxt_load;
        logic out_free;
    } t_dp_stat;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] slot;
    } t_pick;

    // highest slot not taken by the other frame or by either held slot
    function automatic t_pick pick_slot(
        input logic              other_v,
        input logic [SLOT_W-1:0] other,
        input logic              hc_v,
        input logic [SLOT_W-1:0] hc,
        input logic              hn_v,
        input logic [SLOT_W-1:0] hn
    );
        t_pick p;
        logic  ex;
        p = '0;
        for (int s = 0; s < NUM_SLOTS; s++) begin
            ex = (other_v && other == SLOT_W'(s)) || (hc_v && hc == SLOT_W'(s)) ||
                 (hn_v && hn == SLOT_W'(s));
            if (!ex) begin
                p.found = 1'b1;
                p.slot  = SLOT_W'(s);
            end
        end
        return p;
    endfunction

    function automatic logic [OUT_SLOT_W-1:0] slot_out(
        input logic              v,
        input logic [SLOT_W-1:0] s
    );
        logic [SLOT_W+OUT_SLOT_W-1:0] w;
        w = {{OUT_SLOT_W{1'b0}}, s};
        return v ? w[OUT_SLOT_W-1:0] : '0;
    endfunction

    function automatic logic [OUT_PHASE_W-1:0] phase_out(input logic [PHASE_W-1:0] p);
        logic [PHASE_W+OUT_PHASE_W-1:0] w;
        w = {{OUT_PHASE_W{1'b0}}, p};
        return w[OUT_PHASE_W-1:0];
    endfunction

    function automatic logic [FRAME_W-1:0] eff_count(input logic [FRAME_W-1:0] fc);
        return (fc == '0) ? FRAME_W'(1) : fc;
    endfunction

endpackage

FILE: src/apfc_cfg_regs.sv
`timescale 1ns / 1ps
// APB configuration register file.
module apfc_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [apfc_pkg::PADDR_W-1:0] paddr,
    input  logic [apfc_pkg::PDATA_W-1:0] pwdata,
    output logic [apfc_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output apfc_pkg::t_cfg               o_cfg
);

    apfc_pkg::t_cfg   r_cfg;
    apfc_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign pready = 1'b1;
    assign w_idx  = apfc_pkg::t_reg_idx'(paddr[apfc_pkg::PADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{enable:      1'b0,
                       frame_count: apfc_pkg::FRAME_W'(1),
                       speed:       '0,
                       loop_en:     1'b0,
                       pp_en:       1'b0,
                       data_base:   '0,
                       frame_size:  '0};
        end else if (w_wr) begin
            case (w_idx)
                apfc_pkg::REG_ENABLE:      r_cfg.enable      <= pwdata[0];
                apfc_pkg::REG_FRAME_COUNT: r_cfg.frame_count <= pwdata[apfc_pkg::FRAME_W-1:0];
                apfc_pkg::REG_SPEED:       r_cfg.speed       <= pwdata[apfc_pkg::SPEED_W-1:0];
                apfc_pkg::REG_LOOP:        r_cfg.loop_en     <= pwdata[0];
                apfc_pkg::REG_PINGPONG:    r_cfg.pp_en       <= pwdata[0];
                apfc_pkg::REG_DATA_BASE:   r_cfg.data_base   <= pwdata[apfc_pkg::ADDR_W-1:0];
                apfc_pkg::REG_FRAME_SIZE:  r_cfg.frame_size  <= pwdata[apfc_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (w_idx)
            apfc_pkg::REG_ENABLE:      prdata = apfc_pkg::PDATA_W'(r_cfg.enable);
            apfc_pkg::REG_FRAME_COUNT: prdata = apfc_pkg::PDATA_W'(r_cfg.frame_count);
            apfc_pkg::REG_SPEED:       prdata = apfc_pkg::PDATA_W'(r_cfg.speed);
            apfc_pkg::REG_LOOP:        prdata = apfc_pkg::PDATA_W'(r_cfg.loop_en);
            apfc_pkg::REG_PINGPONG:    prdata = apfc_pkg::PDATA_W'(r_cfg.pp_en);
            apfc_pkg::REG_DATA_BASE:   prdata = apfc_pkg::PDATA_W'(r_cfg.data_base);
            apfc_pkg::REG_FRAME_SIZE:  prdata = apfc_pkg::PDATA_W'(r_cfg.frame_size);
            default:                   prdata = '0;
        endcase
    end

endmodule

FILE: src/apfc_ctrl.sv
`timescale 1ns / 1ps
// Tick sequencer: walks one tick through advance passes, cache lookup and result beats.
module apfc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_enable,
    input  apfc_pkg::t_dp_stat i_stat,
    output apfc_pkg::t_dp_cmd  o_cmd
);

    apfc_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= apfc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == apfc_pkg::S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            apfc_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state = i_enable ? apfc_pkg::S_BASE : apfc_pkg::S_DIS;
                end
            end
            apfc_pkg::S_BASE: begin
                if (i_stat.skip) begin
                    n_state = apfc_pkg::S_LOOKUP;
                end else begin
                    o_cmd.calc_base = 1'b1;
                    n_state = apfc_pkg::S_SCALE;
                end
            end
            apfc_pkg::S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state = apfc_pkg::S_PASS;
            end
            apfc_pkg::S_PASS: begin
                o_cmd.step = 1'b1;
                if (i_stat.pass_last) n_state = apfc_pkg::S_FINISH;
            end
            apfc_pkg::S_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state = apfc_pkg::S_LOOKUP;
            end
            apfc_pkg::S_LOOKUP: begin
                o_cmd.lookup = 1'b1;
                n_state = apfc_pkg::S_LOAD_CUR;
            end
            apfc_pkg::S_LOAD_CUR: begin
                if (!i_stat.cur_load) begin
                    n_state = apfc_pkg::S_LOAD_NXT;
                end else if (i_stat.out_free) begin
                    o_cmd.load_cur = 1'b1;
                    n_state = apfc_pkg::S_LOAD_NXT;
                end
            end
            apfc_pkg::S_LOAD_NXT: begin
                if (!i_stat.nxt_load) begin
                    n_state = apfc_pkg::S_STATUS;
                end else if (i_stat.out_free) begin
                    o_cmd.load_nxt = 1'b1;
                    n_state = apfc_pkg::S_STATUS;
                end
            end
            apfc_pkg::S_STATUS: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_status = 1'b1;
                    n_state = apfc_pkg::S_IDLE;
                end
            end
            apfc_pkg::S_DIS: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_dis = 1'b1;
                    n_state = apfc_pkg::S_IDLE;
                end
            end
            default: n_state = apfc_pkg::S_IDLE;
        endcase
    end

    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load_cur, o_cmd.load_nxt, o_cmd.emit_status, o_cmd.emit_dis}))
        else $error("more than one result beat launched in a cycle");

    a_beat_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_cur || o_cmd.load_nxt || o_cmd.emit_status || o_cmd.emit_dis)
        |-> i_stat.out_free)
        else $error("result beat launched over an untaken beat");

    a_one_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> !o_in_ready)
        else $error("new tick taken while one is in progress");

endmodule

FILE: src/apfc_datapath.sv
`timescale 1ns / 1ps
// Phase accumulator, advance pass unit, frame cache tags and output beat register.
module apfc_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  apfc_pkg::t_cfg                   i_cfg,
    input  apfc_pkg::t_dp_cmd                i_cmd,
    output apfc_pkg::t_dp_stat               o_stat,
    input  logic [apfc_pkg::RATE_W-1:0]      i_update_rate,
    input  logic                             i_skip_advance,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_kind,
    output logic [apfc_pkg::OUT_SLOT_W-1:0]  o_slot,
    output logic [apfc_pkg::FRAME_W-1:0]     o_frame_index,
    output logic [apfc_pkg::ADDR_W-1:0]      o_source_address,
    output logic [apfc_pkg::OUT_PHASE_W-1:0] o_phase_now,
    output logic [apfc_pkg::OUT_SLOT_W-1:0]  o_current_slot,
    output logic [apfc_pkg::OUT_SLOT_W-1:0]  o_following_slot,
    output logic                             o_reversed,
    output logic                             o_overrun,
    output logic                             o_last
);

    localparam int ACC_W   = apfc_pkg::ACC_W;
    localparam int PHASE_W = apfc_pkg::PHASE_W;
    localparam int FRAME_W = apfc_pkg::FRAME_W;
    localparam int SLOT_W  = apfc_pkg::SLOT_W;
    localparam int NSL     = apfc_pkg::NUM_SLOTS;

    // architectural state
    logic [PHASE_W-1:0]  r_phase;
    logic                r_dir;
    logic [FRAME_W-1:0]  r_cache_id [NSL];
    logic [NSL-1:0]      r_cache_vld;
    logic [SLOT_W-1:0]   r_held_cur, r_held_nxt;
    logic                r_held_cur_v, r_held_nxt_v;

    // per-tick working registers
    logic [apfc_pkg::RATE_W-1:0]  r_rate;
    logic                         r_skip;
    logic [apfc_pkg::DBASE_W-1:0] r_dbase;
    logic [apfc_pkg::DELTA_W-1:0] r_delta;
    logic [PHASE_W-1:0]           r_limit;
    logic signed [ACC_W-1:0]      r_acc;
    logic [apfc_pkg::PASS_W-1:0]  r_passes;
    logic                         r_ovr;
    logic [FRAME_W-1:0]           r_frame, r_next;
    logic [SLOT_W-1:0]            r_cur, r_nxt;
    logic                         r_cur_v, r_nxt_v;

    // output beat register
    logic                             r_o_valid;
    logic                             r_o_kind;
    logic [apfc_pkg::OUT_SLOT_W-1:0]  r_o_slot;
    logic [FRAME_W-1:0]               r_o_frame;
    logic [apfc_pkg::ADDR_W-1:0]      r_o_addr;
    logic [apfc_pkg::OUT_PHASE_W-1:0] r_o_phase;
    logic [apfc_pkg::OUT_SLOT_W-1:0]  r_o_cur, r_o_fol;
    logic                             r_o_rev, r_o_ovr, r_o_last;

    // combinational
    logic [FRAME_W-1:0]           fc_eff;
    logic [PHASE_W-1:0]           n_limit;
    logic [apfc_pkg::PROD_W-1:0]  base_prod;
    logic signed [ACC_W-1:0]      lim_s, delta_s, sum_f, sum_r, n_acc;
    logic                         n_dir, n_oor, acc_oor;
    logic [FRAME_W-1:0]           ph_frame;
    logic [FRAME_W:0]             nx_wide;
    logic [FRAME_W-1:0]           lk_next;
    logic [SLOT_W-1:0]            lk_cur, lk_nxt;
    logic                         lk_cur_v, lk_nxt_v;
    apfc_pkg::t_pick              pick_c, pick_n;
    logic                         out_free, e_go;
    logic [FRAME_W-1:0]           e_frame;
    logic [apfc_pkg::ADDR_W-1:0]  e_addr;

    assign fc_eff    = apfc_pkg::eff_count(i_cfg.frame_count);
    assign n_limit   = i_cfg.loop_en ?
                       {fc_eff, {apfc_pkg::FRAC_BITS{1'b0}}} - PHASE_W'(1) :
                       {fc_eff - FRAME_W'(1), {apfc_pkg::FRAC_BITS{1'b0}}};
    assign base_prod = apfc_pkg::PROD_W'(i_cfg.speed) * apfc_pkg::PROD_W'(apfc_pkg::RECIP);

    // one advance pass
    assign lim_s   = $signed({{(ACC_W-PHASE_W){1'b0}}, r_limit});
    assign delta_s = $signed({{(ACC_W-apfc_pkg::DELTA_W){1'b0}}, r_delta});
    assign sum_f   = r_acc + delta_s;
    assign sum_r   = r_acc - delta_s;

    always_comb begin
        n_dir = r_dir;
        if (r_dir) begin
            n_acc = sum_r;
            if (sum_r < 0) begin
                if (i_cfg.loop_en && i_cfg.pp_en) begin
                    n_acc = -sum_r;
                    n_dir = 1'b0;
                end else if (i_cfg.loop_en) begin
                    n_acc = sum_r + lim_s;
                end else begin
                    n_acc = '0;
                end
            end
        end else begin
            n_acc = sum_f;
            if (sum_f > lim_s) begin
                if (i_cfg.pp_en) begin
                    n_acc = lim_s + lim_s - sum_f;
                    n_dir = 1'b1;
                end else if (i_cfg.loop_en) begin
                    n_acc = sum_f - lim_s;
                end else begin
                    n_acc = lim_s;
                end
            end
        end
    end

    assign n_oor   = (n_acc < 0) || (n_acc > lim_s);
    assign acc_oor = (r_acc < 0) || (r_acc > lim_s);

    // cache lookup of the frame under the phase and the one after it
    assign ph_frame = r_phase[PHASE_W-1:apfc_pkg::FRAC_BITS];
    assign nx_wide  = {1'b0, ph_frame} + (FRAME_W+1)'(1);
    assign lk_next  = (nx_wide >= {1'b0, fc_eff}) ? '0 : nx_wide[FRAME_W-1:0];

    always_comb begin
        lk_cur   = '0;
        lk_nxt   = '0;
        lk_cur_v = 1'b0;
        lk_nxt_v = 1'b0;
        for (int s = NSL - 1; s >= 0; s--) begin
            if (r_cache_vld[s] && r_cache_id[s] == ph_frame) begin
                lk_cur   = SLOT_W'(s);
                lk_cur_v = 1'b1;
            end
            if (r_cache_vld[s] && r_cache_id[s] == lk_next) begin
                lk_nxt   = SLOT_W'(s);
                lk_nxt_v = 1'b1;
            end
        end
    end

    assign pick_c = apfc_pkg::pick_slot(r_nxt_v, r_nxt, r_held_cur_v, r_held_cur,
                                        r_held_nxt_v, r_held_nxt);
    assign pick_n = apfc_pkg::pick_slot(r_cur_v, r_cur, r_held_cur_v, r_held_cur,
                                        r_held_nxt_v, r_held_nxt);

    assign out_free = !r_o_valid || i_out_ready;

    assign o_stat.skip      = r_skip;
    assign o_stat.pass_last = !n_oor ||
                              (r_passes == apfc_pkg::PASS_W'(apfc_pkg::MAX_PASSES - 1));
    assign o_stat.cur_load  = !r_cur_v && pick_c.found;
    assign o_stat.nxt_load  = !r_nxt_v && pick_n.found;
    assign o_stat.out_free  = out_free;

    // result beat contents
    assign e_go = i_cmd.load_cur || i_cmd.load_nxt || i_cmd.emit_status || i_cmd.emit_dis;

    always_comb begin
        e_frame = r_frame;
        if (i_cmd.load_nxt) e_frame = r_next;
        else if (i_cmd.emit_dis) e_frame = ph_frame;
    end

    // address wraps at 32 bits
    assign e_addr = i_cfg.data_base +
                    apfc_pkg::ADDR_W'(e_frame) * apfc_pkg::ADDR_W'(i_cfg.frame_size);

    // tick working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rate <= i_update_rate;
            r_skip <= i_skip_advance;
        end
        if (i_cmd.calc_base) begin
            r_dbase <= base_prod[apfc_pkg::DIV_K +: apfc_pkg::DBASE_W];
            r_limit <= n_limit;
        end
        if (i_cmd.scale) begin
            r_delta  <= apfc_pkg::DELTA_W'(r_dbase) * apfc_pkg::DELTA_W'(r_rate);
            r_acc    <= $signed({{(ACC_W-PHASE_W){1'b0}}, r_phase});
            r_passes <= '0;
        end
        if (i_cmd.step) begin
            r_acc    <= n_acc;
            r_passes <= r_passes + apfc_pkg::PASS_W'(1);
        end
        if (i_cmd.lookup) begin
            r_frame <= ph_frame;
            r_next  <= lk_next;
            r_cur   <= lk_cur;
            r_nxt   <= lk_nxt;
            r_cur_v <= lk_cur_v;
            r_nxt_v <= lk_nxt_v;
        end
        if (i_cmd.load_cur) begin
            r_cur   <= pick_c.slot;
            r_cur_v <= 1'b1;
        end
        if (i_cmd.load_nxt) begin
            r_nxt   <= pick_n.slot;
            r_nxt_v <= 1'b1;
        end
        if (i_cmd.load_cur) r_cache_id[pick_c.slot] <= r_frame;
        if (i_cmd.load_nxt) r_cache_id[pick_n.slot] <= r_next;
    end

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= '0;
            r_dir        <= 1'b0;
            r_cache_vld  <= '0;
            r_held_cur_v <= 1'b0;
            r_held_nxt_v <= 1'b0;
            r_held_cur   <= '0;
            r_held_nxt   <= '0;
            r_ovr        <= 1'b0;
        end else begin
            if (i_cmd.accept) r_ovr <= 1'b0;
            if (i_cmd.step) r_dir <= n_dir;
            if (i_cmd.finish) begin
                // pass cap hit: pull the phase back into range
                if (r_acc < 0) begin
                    r_phase <= '0;
                    r_ovr   <= 1'b1;
                end else if (r_acc > lim_s) begin
                    r_phase <= r_limit;
                    r_ovr   <= 1'b1;
                end else begin
                    r_phase <= r_acc[PHASE_W-1:0];
                end
            end
            if (i_cmd.load_cur) r_cache_vld[pick_c.slot] <= 1'b1;
            if (i_cmd.load_nxt) r_cache_vld[pick_n.slot] <= 1'b1;
            if (i_cmd.emit_status) begin
                r_held_cur   <= r_cur;
                r_held_cur_v <= r_cur_v;
                r_held_nxt   <= r_nxt;
                r_held_nxt_v <= r_nxt_v;
            end
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (e_go) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_go) begin
            r_o_frame <= e_frame;
            r_o_addr  <= e_addr;
            if (i_cmd.load_cur || i_cmd.load_nxt) begin
                r_o_kind  <= 1'b0;
                r_o_slot  <= apfc_pkg::slot_out(1'b1,
                                 i_cmd.load_cur ? pick_c.slot : pick_n.slot);
                r_o_phase <= '0;
                r_o_cur   <= '0;
                r_o_fol   <= '0;
                r_o_rev   <= 1'b0;
                r_o_ovr   <= 1'b0;
                r_o_last  <= 1'b0;
            end else if (i_cmd.emit_status) begin
                r_o_kind  <= 1'b1;
                r_o_slot  <= '0;
                r_o_phase <= apfc_pkg::phase_out(r_phase);
                r_o_cur   <= apfc_pkg::slot_out(r_cur_v, r_cur);
                r_o_fol   <= apfc_pkg::slot_out(r_nxt_v, r_nxt);
                r_o_rev   <= r_dir;
                r_o_ovr   <= r_ovr;
                r_o_last  <= 1'b1;
            end else begin
                r_o_kind  <= 1'b1;
                r_o_slot  <= '0;
                r_o_phase <= apfc_pkg::phase_out(r_phase);
                r_o_cur   <= apfc_pkg::slot_out(r_held_cur_v, r_held_cur);
                r_o_fol   <= apfc_pkg::slot_out(r_held_nxt_v, r_held_nxt);
                r_o_rev   <= r_dir;
                r_o_ovr   <= 1'b0;
                r_o_last  <= 1'b1;
            end
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_kind           = r_o_kind;
    assign o_slot           = r_o_slot;
    assign o_frame_index    = r_o_frame;
    assign o_source_address = r_o_addr;
    assign o_phase_now      = r_o_phase;
    assign o_current_slot   = r_o_cur;
    assign o_following_slot = r_o_fol;
    assign o_reversed       = r_o_rev;
    assign o_overrun        = r_o_ovr;
    assign o_last           = r_o_last;

    a_phase_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (r_phase <= r_limit))
        else $error("phase left beyond the end after the advance passes");

    a_cur_tagged: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_cur |=> (r_cur_v && r_cache_vld[r_cur] && r_cache_id[r_cur] == r_frame))
        else $error("current frame load did not tag its slot");

    a_nxt_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_nxt |-> !(r_cur_v && pick_n.slot == r_cur))
        else $error("following frame load evicts the current frame");

    a_acc_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish && acc_oor |-> (r_passes == apfc_pkg::PASS_W'(apfc_pkg::MAX_PASSES)))
        else $error("phase out of range before the pass cap");

endmodule

FILE: src/animation_phase_frame_cache_unit.sv
`timescale 1ns / 1ps
// Top level of the animation phase frame cache.
//
// Input channel (i_in_valid / o_in_ready) takes one tick beat per video frame:
// i_update_rate and i_skip_advance. Output channel (o_out_valid / i_out_ready)
// returns up to two upload request beats (kind 0), one per frame loaded into
// the frame cache, then one status beat (kind 1, last 1) that ends the tick.
// Configuration is written through the APB port, one register every 4 bytes;
// the user must write it only while no tick is in progress; nothing enforces it.
//
// A tick walks the sequencer through base, scale, the advance passes (one
// advance pass per cycle, at most eight of them), finish, lookup, the frame
// loads that are needed and the status beat. A skipped tick goes from base
// straight to lookup; a tick while disabled goes straight to its status beat.
// The output register lets the next tick be taken while the status beat of
// the last one waits; a stalled receiver holds the sequencer at its next
// result beat.
// Reset clears the phase, sets forward playback, empties all cache slots and
// loads the register reset values; no tick is in flight afterwards.
module animation_phase_frame_cache_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [apfc_pkg::PADDR_W-1:0]     paddr,
    input  logic [apfc_pkg::PDATA_W-1:0]     pwdata,
    output logic [apfc_pkg::PDATA_W-1:0]     prdata,
    output logic                             pready,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [apfc_pkg::RATE_W-1:0]      i_update_rate,
    input  logic                             i_skip_advance,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_kind,
    output logic [apfc_pkg::OUT_SLOT_W-1:0]  o_slot,
    output logic [apfc_pkg::FRAME_W-1:0]     o_frame_index,
    output logic [apfc_pkg::ADDR_W-1:0]      o_source_address,
    output logic [apfc_pkg::OUT_PHASE_W-1:0] o_phase_now,
    output logic [apfc_pkg::OUT_SLOT_W-1:0]  o_current_slot,
    output logic [apfc_pkg::OUT_SLOT_W-1:0]  o_following_slot,
    output logic                             o_reversed,
    output logic                             o_overrun,
    output logic                             o_last
);

    apfc_pkg::t_cfg     cfg;
    apfc_pkg::t_dp_cmd  cmd;
    apfc_pkg::t_dp_stat stat;

    apfc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    apfc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_enable   (cfg.enable),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    apfc_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (cfg),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_update_rate    (i_update_rate),
        .i_skip_advance   (i_skip_advance),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_kind           (o_kind),
        .o_slot           (o_slot),
        .o_frame_index    (o_frame_index),
        .o_source_address (o_source_address),
        .o_phase_now      (o_phase_now),
        .o_current_slot   (o_current_slot),
        .o_following_slot (o_following_slot),
        .o_reversed       (o_reversed),
        .o_overrun        (o_overrun),
        .o_last           (o_last)
    );

endmodule
